/* rtl/epcs_pkg.sv */
package epcs_pkg;

  localparam int unsigned NUM_CHAN = 3;

  // Channel slots in the per-channel arrays and in flat_mask
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  // Request kinds carried in req_type
  localparam logic REQ_GATHER = 1'b0;
  localparam logic REQ_MAP    = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic gather;    // fold the accepted pixel into the extremes
    logic map_load;  // latch operands of a map pixel, seed the divider
    logic div_step;  // retire one quotient bit in every channel
    logic out_load;  // move the finished result into the output register
  } epcs_cmd_t;

endpackage

/* rtl/epcs_if.sv */
interface epcs_pix_if #(
  parameter int unsigned CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic                    frame_start;
  logic [CHANNEL_BITS-1:0] red_in;
  logic [CHANNEL_BITS-1:0] green_in;
  logic [CHANNEL_BITS-1:0] blue_in;

  modport source (
    output valid, req_type, frame_start, red_in, green_in, blue_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, frame_start, red_in, green_in, blue_in,
    output ready
  );
endinterface

interface epcs_res_if #(
  parameter int unsigned CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_out;
  logic [CHANNEL_BITS-1:0] green_out;
  logic [CHANNEL_BITS-1:0] blue_out;
  logic [2:0]              flat_mask;

  modport source (
    output valid, red_out, green_out, blue_out, flat_mask,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, flat_mask,
    output ready
  );
endinterface

/* rtl/epcs_ctrl.sv */
module epcs_ctrl #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pix_valid_i,
  input  logic               pix_req_type_i,
  output logic               pix_ready_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output epcs_pkg::epcs_cmd_t cmd_o
);

  localparam int unsigned CW = $clog2(CHANNEL_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          pix_acc;

  assign pix_ready_o = (state_q == ST_IDLE);
  assign pix_acc     = pix_valid_i && pix_ready_o;
  assign res_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.gather   = pix_acc && (pix_req_type_i == epcs_pkg::REQ_GATHER);
    cmd_o.map_load = pix_acc && (pix_req_type_i == epcs_pkg::REQ_MAP);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.out_load = (state_q == ST_DONE) && (!out_valid_q || res_ready_i);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.map_load) begin
          state_d = ST_DIV;
          cnt_d   = CW'(CHANNEL_BITS - 1);
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (cmd_o.out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || res_ready_i))
    else $error("output register overwritten while full");

  // A map pixel runs exactly CHANNEL_BITS divider steps
  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.map_load |=> ##(CHANNEL_BITS) (state_q == ST_DONE))
    else $error("divider did not finish in CHANNEL_BITS steps");

  // Loading the output register raises valid on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result loaded but valid not raised");

  // No pixel accepted while the divider is busy
  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !(cmd_o.gather || cmd_o.map_load))
    else $error("pixel accepted while busy");

endmodule

/* rtl/epcs_dp.sv */
module epcs_dp #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  epcs_pkg::epcs_cmd_t     cmd_i,
  input  logic                    frame_start_i,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  output logic [CHANNEL_BITS-1:0] red_o,
  output logic [CHANNEL_BITS-1:0] green_o,
  output logic [CHANNEL_BITS-1:0] blue_o,
  output logic [2:0]              flat_mask_o
);

  localparam int unsigned W  = CHANNEL_BITS;
  localparam int unsigned NC = epcs_pkg::NUM_CHAN;
  localparam int unsigned SW = W + 2;      // channel sum
  localparam int unsigned XW = 2 * W + 2;  // dividend 2*M*n + d
  localparam int unsigned DW = 2 * W;      // shifted divisor 2*d << (W-1)

  logic [NC-1:0][W-1:0] pix;
  logic [SW-1:0]        sum;

  // Gather state
  logic [SW-1:0]        bright_sum_q, dark_sum_q;
  logic [NC-1:0][W-1:0] white_q, dark_q;

  // Divider state
  logic [NC-1:0][XW-1:0] x_q;
  logic [NC-1:0][DW-1:0] ds_q;
  logic [NC-1:0][W-1:0]  quo_q;
  logic [NC-1:0]         zero_q, sat_q, flat_q;

  // Map operand preparation
  logic [NC-1:0][W:0]    num, den;
  logic [NC-1:0][W-1:0]  n_mag, d_mag;
  logic [NC-1:0][XW-1:0] x_init;
  logic [NC-1:0]         flat_c, zero_c, sat_c;

  // Divider step
  logic [NC-1:0]         ge;
  logic [NC-1:0][XW-1:0] x_next;

  // Output register
  logic [NC-1:0][W-1:0]  res_q;
  logic [NC-1:0][W-1:0]  res_c;
  logic [NC-1:0]         mask_q;

  assign pix[epcs_pkg::CH_RED]   = red_i;
  assign pix[epcs_pkg::CH_GREEN] = green_i;
  assign pix[epcs_pkg::CH_BLUE]  = blue_i;

  assign sum = SW'(red_i) + SW'(green_i) + SW'(blue_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_sum_q <= '0;
      dark_sum_q   <= '0;
      white_q      <= '0;
      dark_q       <= '0;
    end else if (cmd_i.gather) begin
      if (frame_start_i) begin
        bright_sum_q <= sum;
        dark_sum_q   <= sum;
        white_q      <= pix;
        dark_q       <= pix;
      end else begin
        if (sum > bright_sum_q) begin
          bright_sum_q <= sum;
          white_q      <= pix;
        end
        if (sum < dark_sum_q) begin
          dark_sum_q <= sum;
          dark_q     <= pix;
        end
      end
    end
  end

  // With n >= d the rounded quotient is at least M, so it saturates; otherwise
  // it fits in W bits and W restoring steps produce it exactly.
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      num[k]    = {1'b0, pix[k]} - {1'b0, dark_q[k]};
      den[k]    = {1'b0, white_q[k]} - {1'b0, dark_q[k]};
      n_mag[k]  = num[k][W] ? W'(~num[k] + 1'b1) : num[k][W-1:0];
      d_mag[k]  = den[k][W] ? W'(~den[k] + 1'b1) : den[k][W-1:0];
      flat_c[k] = (den[k] == '0);
      zero_c[k] = flat_c[k] || (num[k] == '0) || (num[k][W] != den[k][W]);
      sat_c[k]  = (n_mag[k] >= d_mag[k]);
      x_init[k] = (XW'(n_mag[k]) << (W + 1)) - (XW'(n_mag[k]) << 1) + XW'(d_mag[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      ge[k]     = (x_q[k] >= XW'(ds_q[k]));
      x_next[k] = ge[k] ? (x_q[k] - XW'(ds_q[k])) : x_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_load) begin
      for (int k = 0; k < NC; k++) begin
        x_q[k]    <= x_init[k];
        ds_q[k]   <= {d_mag[k], {W{1'b0}}};
        quo_q[k]  <= '0;
      end
      zero_q <= zero_c;
      sat_q  <= sat_c;
      flat_q <= flat_c;
    end else if (cmd_i.div_step) begin
      for (int k = 0; k < NC; k++) begin
        x_q[k]   <= x_next[k];
        ds_q[k]  <= ds_q[k] >> 1;
        quo_q[k] <= {quo_q[k][W-2:0], ge[k]};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      if (zero_q[k]) begin
        res_c[k] = '0;
      end else if (sat_q[k]) begin
        res_c[k] = '1;
      end else begin
        res_c[k] = quo_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q  <= res_c;
      mask_q <= flat_q;
    end
  end

  assign red_o       = res_q[epcs_pkg::CH_RED];
  assign green_o     = res_q[epcs_pkg::CH_GREEN];
  assign blue_o      = res_q[epcs_pkg::CH_BLUE];
  assign flat_mask_o = mask_q;

endmodule

/* rtl/extreme_pixel_contrast_stretch.sv */
// Channel   Dir  Handshake          Word
// pix_i     in   valid / ready      req_type, frame_start, red_in, green_in, blue_in
// res_o     out  valid / ready      red_out, green_out, blue_out, flat_mask
//
// A gather pixel is folded into the extremes when accepted and yields no word.
// A map pixel is taken in, runs CHANNEL_BITS steps of the shift-subtract
// divider (one quotient bit per cycle, all three channels side by side), then
// has its result moved into the output register.
// Reset clears the extremes to zero color and sum 0 and empties the output.
// A word still waiting on res_o holds the next map pixel in its final cycle;
// pix_i then stays blocked, gather pixels included, until that word leaves.
module extreme_pixel_contrast_stretch #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  epcs_pix_if.sink            pix_i,
  epcs_res_if.source          res_o
);

  epcs_pkg::epcs_cmd_t cmd;

  // Sequencing: accept, divider step count, output slot
  epcs_ctrl #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_valid_i    (pix_i.valid),
    .pix_req_type_i (pix_i.req_type),
    .pix_ready_o    (pix_i.ready),
    .res_valid_o    (res_o.valid),
    .res_ready_i    (res_o.ready),
    .cmd_o          (cmd)
  );

  // Extremes tracking, per-channel divider, output register
  epcs_dp #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .frame_start_i (pix_i.frame_start),
    .red_i         (pix_i.red_in),
    .green_i       (pix_i.green_in),
    .blue_i        (pix_i.blue_in),
    .red_o         (res_o.red_out),
    .green_o       (res_o.green_out),
    .blue_o        (res_o.blue_out),
    .flat_mask_o   (res_o.flat_mask)
  );

endmodule

/* verif/extreme_pixel_contrast_stretch_checker.sv */
`timescale 1ns / 100ps

module extreme_pixel_contrast_stretch_checker #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  epcs_pix_if         pix_i,
  epcs_res_if         res_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  localparam longint MAXV        = (longint'(1) << CHANNEL_BITS) - 1;
  localparam int     REPORT_MAX  = 10;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [CHANNEL_BITS+1:0] sum_t;

  typedef struct packed {
    chan_t                         red;
    chan_t                         green;
    chan_t                         blue;
    logic [epcs_pkg::NUM_CHAN-1:0] flat;
  } stretched_word_t;

  // Running extremes of the current frame
  sum_t  peak_sum;
  sum_t  floor_sum;
  chan_t peak_color  [epcs_pkg::NUM_CHAN];
  chan_t floor_color [epcs_pkg::NUM_CHAN];

  stretched_word_t pending_words [$];

  // Scale one channel between its floor and peak levels, round half up, clamp
  function automatic chan_t stretched_level(input chan_t level, input chan_t lo,
                                            input chan_t hi, output logic flat);
    longint num;
    longint den;
    longint q;
    flat = 1'b0;
    num  = level;
    num -= lo;
    den  = hi;
    den -= lo;
    if (den == 0) begin
      flat = 1'b1;
      return '0;
    end
    if (num == 0 || ((num < 0) != (den < 0))) return '0;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    q = (2 * MAXV * num + den) / (2 * den);
    if (q > MAXV) q = MAXV;
    return chan_t'(q);
  endfunction

  always @(posedge clk_i) begin
    chan_t           px  [epcs_pkg::NUM_CHAN];
    chan_t           lvl [epcs_pkg::NUM_CHAN];
    sum_t            level_sum;
    logic            flat_bit;
    stretched_word_t exp_w;
    stretched_word_t got_w;
    if (!rst_ni) begin
      peak_sum  = '0;
      floor_sum = '0;
      foreach (peak_color[ch]) begin
        peak_color[ch]  = '0;
        floor_color[ch] = '0;
      end
      pending_words.delete();
      error_count_o = 0;
    end else begin
      // Compare the departing word against the oldest prediction
      if (res_i.valid && res_i.ready) begin
        got_w = '{red: res_i.red_out, green: res_i.green_out, blue: res_i.blue_out,
                  flat: res_i.flat_mask};
        if (pending_words.size() == 0) begin
          error_count_o++;
          if (error_count_o <= REPORT_MAX)
            $display("%0t: unexpected word r=%0d g=%0d b=%0d flat=%b", $time,
                     got_w.red, got_w.green, got_w.blue, got_w.flat);
        end else begin
          exp_w = pending_words.pop_front();
          if (got_w.red !== exp_w.red || got_w.green !== exp_w.green ||
              got_w.blue !== exp_w.blue || got_w.flat !== exp_w.flat) begin
            error_count_o++;
            if (error_count_o <= REPORT_MAX)
              $display({"%0t: word mismatch, expected r=%0d g=%0d b=%0d flat=%b,",
                        " got r=%0d g=%0d b=%0d flat=%b"},
                       $time, exp_w.red, exp_w.green, exp_w.blue, exp_w.flat,
                       got_w.red, got_w.green, got_w.blue, got_w.flat);
          end
        end
      end

      // Fold in or stretch the arriving pixel
      if (pix_i.valid && pix_i.ready) begin
        px[epcs_pkg::CH_RED]   = pix_i.red_in;
        px[epcs_pkg::CH_GREEN] = pix_i.green_in;
        px[epcs_pkg::CH_BLUE]  = pix_i.blue_in;
        level_sum = sum_t'(px[epcs_pkg::CH_RED]) + sum_t'(px[epcs_pkg::CH_GREEN]) +
                    sum_t'(px[epcs_pkg::CH_BLUE]);
        if (pix_i.req_type == epcs_pkg::REQ_GATHER) begin
          if (pix_i.frame_start) begin
            peak_sum    = level_sum;
            floor_sum   = level_sum;
            peak_color  = px;
            floor_color = px;
          end else begin
            if (level_sum > peak_sum) begin
              peak_sum   = level_sum;
              peak_color = px;
            end
            if (level_sum < floor_sum) begin
              floor_sum   = level_sum;
              floor_color = px;
            end
          end
        end else begin
          foreach (px[ch]) begin
            lvl[ch] = stretched_level(px[ch], floor_color[ch], peak_color[ch], flat_bit);
            exp_w.flat[ch] = flat_bit;
          end
          exp_w.red   = lvl[epcs_pkg::CH_RED];
          exp_w.green = lvl[epcs_pkg::CH_GREEN];
          exp_w.blue  = lvl[epcs_pkg::CH_BLUE];
          pending_words.push_back(exp_w);
        end
      end
    end
    pending_o = pending_words.size();
  end

endmodule

/* verif/extreme_pixel_contrast_stretch_tb.sv */
`timescale 1ns / 100ps

module extreme_pixel_contrast_stretch_tb;

  localparam int unsigned CHANNEL_BITS  = 8;
  localparam int unsigned MAXV          = (1 << CHANNEL_BITS) - 1;
  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned PIXELS_TARGET = 900;
  // Pixels per idling phase; the phases rotate through the random part
  localparam int unsigned PHASE_LEN     = 60;
  // Give the tail some slack after the last map pixel
  localparam int unsigned DRAIN_CYCLES  = 2 * (CHANNEL_BITS + 2);
  localparam int unsigned RUN_CYCLES    = 400000;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  localparam chan_t LEVEL_MAX = chan_t'(MAXV);

  typedef enum int unsigned {
    PH_STEADY,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH
  } idle_phase_e;

  typedef enum int unsigned {
    MODE_WIDE,    // channels spread over the full range
    MODE_NARROW,  // channels in a 16-level band: large gains, heavy clamping
    MODE_PINNED   // one channel constant over the frame: flat denominator
  } color_mode_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned sent      = 0;
  int unsigned error_count;
  int unsigned pending;

  epcs_pix_if #(.CHANNEL_BITS(CHANNEL_BITS)) pix_if ();
  epcs_res_if #(.CHANNEL_BITS(CHANNEL_BITS)) res_if ();

  extreme_pixel_contrast_stretch #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  extreme_pixel_contrast_stretch_checker #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix_if),
    .res_i         (res_if),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Receiver: drop ready at random by the current stall rate, one update per
  // falling edge so the DUT sees a stable ready at the rising edge.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Hard stop in case the pipe hangs
  initial begin
    #(RUN_CYCLES * CLK_PERIOD);
    $display("[extreme_pixel_contrast_stretch] ERROR");
    $finish;
  end

  // Present one pixel word and hold it until the DUT takes it. Entered and
  // left at a falling edge; valid is never lowered and raised in one step.
  task automatic send_pixel(input logic req, input logic fs,
                            input chan_t r, input chan_t g, input chan_t b);
    // Insert sender gaps by the current idle rate
    while ($urandom_range(99) < idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.req_type    <= req;
    pix_if.frame_start <= fs;
    pix_if.red_in      <= r;
    pix_if.green_in    <= g;
    pix_if.blue_in     <= b;
    // Hold the word until a rising edge sees ready
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  // Pick one channel level for a pixel of the current frame
  function automatic chan_t frame_channel(input color_mode_e mode, input chan_t base_v,
                                          input logic pin);
    if (pin) return base_v;
    if (mode == MODE_NARROW) return base_v + chan_t'($urandom_range(15));
    return chan_t'($urandom_range(MAXV));
  endfunction

  // One frame: a seeded gather run, then map pixels against its extremes.
  // About one frame in ten is broken: missing seed, seeds mid-run, gathers
  // mixed into the map run.
  task automatic send_frame();
    color_mode_e mode;
    chan_t       base [epcs_pkg::NUM_CHAN];
    chan_t       px   [epcs_pkg::NUM_CHAN];
    int unsigned pick;
    int unsigned pin_ch;
    int unsigned n_gather;
    int unsigned n_map;
    logic        broken;
    logic        fs;
    pick     = $urandom_range(99);
    mode     = (pick < 60) ? MODE_WIDE : (pick < 85) ? MODE_NARROW : MODE_PINNED;
    pin_ch   = $urandom_range(epcs_pkg::NUM_CHAN - 1);
    foreach (base[ch]) base[ch] = chan_t'($urandom_range(MAXV - 15));
    if (mode == MODE_PINNED) base[pin_ch] = chan_t'($urandom_range(MAXV));
    broken   = ($urandom_range(9) == 0);
    n_gather = $urandom_range(7);
    n_map    = $urandom_range(1, 12);

    for (int k = 0; k <= n_gather; k++) begin
      foreach (px[ch])
        px[ch] = frame_channel(mode, base[ch], mode == MODE_PINNED && ch == pin_ch);
      if (k == 0) fs = !(broken && $urandom_range(1));
      else        fs = broken && ($urandom_range(4) == 0);
      send_pixel(epcs_pkg::REQ_GATHER, fs, px[epcs_pkg::CH_RED], px[epcs_pkg::CH_GREEN],
                 px[epcs_pkg::CH_BLUE]);
    end

    for (int k = 0; k < n_map; k++) begin
      if (broken && $urandom_range(3) == 0) begin
        foreach (px[ch]) px[ch] = chan_t'($urandom_range(MAXV));
        send_pixel(epcs_pkg::REQ_GATHER, 1'b0, px[epcs_pkg::CH_RED],
                   px[epcs_pkg::CH_GREEN], px[epcs_pkg::CH_BLUE]);
      end else begin
        // Half the map levels come from the frame's range, half from anywhere,
        // so pixels outside the extremes get clamped
        foreach (px[ch])
          px[ch] = $urandom_range(1) ? frame_channel(mode, base[ch], 1'b0)
                                     : chan_t'($urandom_range(MAXV));
        // frame_start on a map pixel must have no effect
        send_pixel(epcs_pkg::REQ_MAP, $urandom_range(7) == 0, px[epcs_pkg::CH_RED],
                   px[epcs_pkg::CH_GREEN], px[epcs_pkg::CH_BLUE]);
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    pix_if.valid       = 1'b0;
    pix_if.req_type    = epcs_pkg::REQ_GATHER;
    pix_if.frame_start = 1'b0;
    pix_if.red_in      = '0;
    pix_if.green_in    = '0;
    pix_if.blue_in     = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, no idling.
    // Map straight after reset: all extremes zero, every channel flat.
    send_pixel(epcs_pkg::REQ_MAP,    1'b0, LEVEL_MAX, 0,   128);
    // Unseeded gather after reset: compared with the zero extremes
    send_pixel(epcs_pkg::REQ_GATHER, 1'b0, 200,  100, 50);
    send_pixel(epcs_pkg::REQ_MAP,    1'b0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX); // clamp high
    send_pixel(epcs_pkg::REQ_MAP,    1'b0, 0,    0,   0);       // zero numerator
    send_pixel(epcs_pkg::REQ_MAP,    1'b0, 100,  50,  25);      // exact halves round up
    // Seed with one pixel: peak equals floor, all channels flat
    send_pixel(epcs_pkg::REQ_GATHER, 1'b1, 100,  100, 100);
    send_pixel(epcs_pkg::REQ_MAP,    1'b1, 50,   100, 200);
    // Strictly darker and brighter pixels move the extremes, ties do not
    send_pixel(epcs_pkg::REQ_GATHER, 1'b0, 10,   20,  30);
    send_pixel(epcs_pkg::REQ_GATHER, 1'b0, 250,  240, 230);
    send_pixel(epcs_pkg::REQ_GATHER, 1'b0, 240,  250, 230);
    send_pixel(epcs_pkg::REQ_GATHER, 1'b0, 20,   10,  30);
    send_pixel(epcs_pkg::REQ_MAP,    1'b0, 5,    LEVEL_MAX, 29); // below the floor: clamp low
    send_pixel(epcs_pkg::REQ_MAP,    1'b0, 130,  130, 130);
    // Floor channel above the peak channel: negative denominator
    send_pixel(epcs_pkg::REQ_GATHER, 1'b1, 200,  0,   0);
    send_pixel(epcs_pkg::REQ_GATHER, 1'b0, 0,    150, 150);
    send_pixel(epcs_pkg::REQ_MAP,    1'b0, 100,  75,  200);
    send_pixel(epcs_pkg::REQ_MAP,    1'b0, LEVEL_MAX, 0, 0);    // opposite signs
    // Full-range extremes
    send_pixel(epcs_pkg::REQ_GATHER, 1'b1, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
    send_pixel(epcs_pkg::REQ_GATHER, 1'b0, 0,    0,   0);
    send_pixel(epcs_pkg::REQ_MAP,    1'b0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
    send_pixel(epcs_pkg::REQ_MAP,    1'b0, 1,    LEVEL_MAX - 1'b1, 128);
    // Single-level spread in one channel, the other two flat
    send_pixel(epcs_pkg::REQ_GATHER, 1'b1, 0,    0,   0);
    send_pixel(epcs_pkg::REQ_MAP,    1'b0, 0,    0,   0);
    send_pixel(epcs_pkg::REQ_GATHER, 1'b0, 0,    0,   1);
    send_pixel(epcs_pkg::REQ_MAP,    1'b0, 0,    0,   1);

    // Random frames; rotate the idling phase every PHASE_LEN pixels
    while (sent < PIXELS_TARGET) begin
      case (idle_phase_e'((sent / PHASE_LEN) % 4))
        PH_STEADY: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        PH_SENDER_IDLE: begin
          idle_pct  = 78;
          stall_pct = 0;
        end
        PH_RECEIVER_STALL: begin
          idle_pct  = 0;
          stall_pct = 78;
        end
        default: begin
          idle_pct  = 8;
          stall_pct = 8;
        end
      endcase
      send_frame();
    end
    pix_if.valid <= 1'b0;

    // Drain: wait for every predicted word, then let the pipe settle
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (error_count == 0 && pending == 0) begin
      $display("[extreme_pixel_contrast_stretch] OK");
    end else begin
      $display("[extreme_pixel_contrast_stretch] ERROR");
    end
    $finish;
  end

endmodule
